FILE: rtl/core/cpc_pkg.sv
`default_nettype none
package cpc_pkg;

   localparam int PACKET_BYTES_DEF = 32;
   localparam int ARG_BYTES_DEF    = 21;

   localparam int COUNT_W   = 6;
   localparam int BYTE_W    = 8;
   localparam int CRC_W     = 16;
   localparam int ARG_IDX_W = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic [COUNT_W-1:0] MAGIC_POS = 6'd0;
   localparam logic [COUNT_W-1:0] TYPE_POS  = 6'd2;
   localparam logic [COUNT_W-1:0] CMD_POS   = 6'd8;
   localparam logic [COUNT_W-1:0] ARG_FIRST = 6'd9;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_BYTE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_TYPE = 1'd1;

   typedef struct packed {
      logic                 accept;
      logic                 load_reject;
      logic                 load_arg;
      logic [ARG_IDX_W-1:0] drain_idx;
   } cpc_cmd_type;

   typedef struct packed {
      logic count_at_end;
      logic last_byte;
      logic pkt_ok;
   } cpc_status_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cpc_req_if.sv
`default_nettype none
interface cpc_req_if;
   logic                          valid;
   logic                          ready;
   logic [cpc_pkg::BYTE_W-1:0]    data_byte;
   logic                          packet_start;

   modport source (output valid, output data_byte, output packet_start, input ready);
   modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cpc_rsp_if.sv
`default_nettype none
interface cpc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            accepted;
   logic [cpc_pkg::BYTE_W-1:0]      command;
   logic [cpc_pkg::BYTE_W-1:0]      arg_value;
   logic [cpc_pkg::ARG_IDX_W-1:0]   arg_index;
   logic                            last;

   modport source (output valid, output accepted, output command, output arg_value,
                   output arg_index, output last, input ready);
   modport sink   (input valid, input accepted, input command, input arg_value,
                   input arg_index, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cpc_ctrl.sv
`default_nettype none
module cpc_ctrl #(
   parameter int ARG_BYTES = cpc_pkg::ARG_BYTES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire cpc_pkg::cpc_status_type status,
   output cpc_pkg::cpc_cmd_type         cmd
);

   localparam logic ST_RECV  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;
   localparam logic [cpc_pkg::ARG_IDX_W-1:0] LAST_IDX = cpc_pkg::ARG_IDX_W'(ARG_BYTES - 1);

   logic                          state_ff, state_in;
   logic [cpc_pkg::ARG_IDX_W-1:0] idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;
   logic                          accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // a closing byte may need the output register for a reject, so hold it off
   assign req_ready = (state_ff == ST_RECV) && !(status.count_at_end && rsp_valid_ff);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      cmd.accept       = accept;
      cmd.load_reject  = 1'b0;
      cmd.load_arg     = 1'b0;
      cmd.drain_idx    = idx_ff;
      case (state_ff)
         ST_RECV: begin
            if (accept && status.last_byte) begin
               if (status.pkt_ok) begin
                  state_in = ST_DRAIN;
                  idx_in   = '0;
               end else begin
                  cmd.load_reject = 1'b1;
                  rsp_valid_in    = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               cmd.load_arg = 1'b1;
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_RECV;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECV;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/core/cpc_datapath.sv
`default_nettype none
module cpc_datapath #(
   parameter int PACKET_BYTES = cpc_pkg::PACKET_BYTES_DEF,
   parameter int ARG_BYTES    = cpc_pkg::ARG_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [cpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cpc_pkg::BYTE_W-1:0]      csr_wdata,
   input  wire logic [cpc_pkg::BYTE_W-1:0]      data_byte,
   input  wire logic                            packet_start,
   input  wire cpc_pkg::cpc_cmd_type            cmd,
   output cpc_pkg::cpc_status_type              status,
   output logic                                 rsp_accepted,
   output logic [cpc_pkg::BYTE_W-1:0]           rsp_command,
   output logic [cpc_pkg::BYTE_W-1:0]           rsp_arg_value,
   output logic [cpc_pkg::ARG_IDX_W-1:0]        rsp_arg_index,
   output logic                                 rsp_last
);

   localparam int ADDR_W = (ARG_BYTES > 1) ? $clog2(ARG_BYTES) : 1;
   localparam logic [cpc_pkg::COUNT_W-1:0] END_POS = cpc_pkg::COUNT_W'(PACKET_BYTES - 1);
   localparam logic [cpc_pkg::COUNT_W-1:0] CRC_END = cpc_pkg::COUNT_W'(PACKET_BYTES - 2);
   localparam logic [cpc_pkg::COUNT_W-1:0] ARG_END =
      cpc_pkg::COUNT_W'(ARG_BYTES) + cpc_pkg::ARG_FIRST;
   localparam logic [cpc_pkg::ARG_IDX_W-1:0] LAST_IDX = cpc_pkg::ARG_IDX_W'(ARG_BYTES - 1);

   logic [cpc_pkg::BYTE_W-1:0]  magic_ff, type_ff;
   logic [cpc_pkg::COUNT_W-1:0] count_ff;
   logic [cpc_pkg::CRC_W-1:0]   crc_ff;
   logic                        hdr_ok_ff;
   logic [cpc_pkg::BYTE_W-1:0]  command_ff, crc_low_ff;
   logic [cpc_pkg::BYTE_W-1:0]  arg_mem [ARG_BYTES];

   logic [cpc_pkg::COUNT_W-1:0] pos;
   logic [cpc_pkg::CRC_W-1:0]   crc_base, crc_in;
   logic                        hdr_base, hdr_in;
   logic [cpc_pkg::COUNT_W-1:0] arg_off;
   logic                        arg_wr;

   assign pos      = packet_start ? '0 : count_ff;
   assign crc_base = packet_start ? cpc_pkg::CRC_INIT : crc_ff;
   assign hdr_base = packet_start ? 1'b1 : hdr_ok_ff;
   assign crc_in   = (pos < CRC_END) ? cpc_pkg::crc_byte(crc_base, data_byte) : crc_base;
   assign hdr_in   = hdr_base
                     && !(pos == cpc_pkg::MAGIC_POS && data_byte != magic_ff)
                     && !(pos == cpc_pkg::TYPE_POS && data_byte != type_ff);
   assign arg_off  = pos - cpc_pkg::ARG_FIRST;
   assign arg_wr   = cmd.accept && pos >= cpc_pkg::ARG_FIRST && pos < ARG_END;

   assign status.count_at_end = (count_ff == END_POS);
   assign status.last_byte    = (pos == END_POS);
   assign status.pkt_ok       = hdr_in && ({data_byte, crc_low_ff} == crc_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
         type_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cpc_pkg::CSR_MAGIC_BYTE:   magic_ff <= csr_wdata;
            cpc_pkg::CSR_COMMAND_TYPE: type_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_ff     <= cpc_pkg::CRC_INIT;
         hdr_ok_ff  <= 1'b1;
         command_ff <= '0;
         crc_low_ff <= '0;
      end else if (cmd.accept) begin
         if (status.last_byte) begin
            count_ff  <= '0;
            crc_ff    <= cpc_pkg::CRC_INIT;
            hdr_ok_ff <= 1'b1;
         end else begin
            count_ff  <= pos + 1'b1;
            crc_ff    <= crc_in;
            hdr_ok_ff <= hdr_in;
         end
         if (pos == cpc_pkg::CMD_POS) begin
            command_ff <= data_byte;
         end
         if (pos == CRC_END) begin
            crc_low_ff <= data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (arg_wr) begin
         arg_mem[arg_off[ADDR_W-1:0]] <= data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_reject) begin
         rsp_accepted  <= 1'b0;
         rsp_command   <= '0;
         rsp_arg_value <= '0;
         rsp_arg_index <= '0;
         rsp_last      <= 1'b1;
      end else if (cmd.load_arg) begin
         rsp_accepted  <= 1'b1;
         rsp_command   <= command_ff;
         rsp_arg_value <= arg_mem[cmd.drain_idx[ADDR_W-1:0]];
         rsp_arg_index <= cmd.drain_idx;
         rsp_last      <= (cmd.drain_idx == LAST_IDX);
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/command_packet_checker.sv
`default_nettype none
// Command packet checker. Packets of PACKET_BYTES bytes arrive one byte per
// req transfer; packet_start marks byte 0 and drops any partial packet without
// a result, and after the last byte the next byte counts as byte 0 anyway.
// Byte 0 must match the magic_byte register (csr index 0) and byte 2 the
// command_type register (csr index 1). A CRC-16/CCITT-FALSE runs over every
// byte but the last two, which hold the expected CRC low byte first. A good
// packet yields ARG_BYTES rsp transfers (accepted = 1, command from byte 8,
// argument bytes 9 onward with their index, last on the final one); a bad
// packet yields one reject transfer with all fields zero and last = 1.
// Timing: bytes are taken at one per cycle while req is ready, and the CRC
// for each byte is updated in the same cycle. A good packet then drains its
// arguments from the argument store at one per cycle through the output
// register while rsp is ready, with req held off meanwhile. The closing
// byte of a packet waits until the output register is empty. The user must
// write the registers through csr_we/csr_index/csr_wdata only while the
// block is idle; the block itself does not enforce this.
module command_packet_checker #(
   parameter int PACKET_BYTES = cpc_pkg::PACKET_BYTES_DEF,
   parameter int ARG_BYTES    = cpc_pkg::ARG_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cpc_req_if.sink                             req,
   cpc_rsp_if.source                           rsp,
   input  wire logic                           csr_we,
   input  wire logic [cpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cpc_pkg::BYTE_W-1:0]     csr_wdata
);

   cpc_pkg::cpc_cmd_type    cmd;
   cpc_pkg::cpc_status_type status;

   // sequence the packet: receive bytes, then drain arguments or reject
   cpc_ctrl #(
      .ARG_BYTES (ARG_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // count, CRC, header check, argument store and result payload
   cpc_datapath #(
      .PACKET_BYTES (PACKET_BYTES),
      .ARG_BYTES    (ARG_BYTES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .data_byte     (req.data_byte),
      .packet_start  (req.packet_start),
      .cmd           (cmd),
      .status        (status),
      .rsp_accepted  (rsp.accepted),
      .rsp_command   (rsp.command),
      .rsp_arg_value (rsp.arg_value),
      .rsp_arg_index (rsp.arg_index),
      .rsp_last      (rsp.last)
   );

   // a reject is always a single, final transfer
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.accepted |-> rsp.last)
      else $error("reject result without last");

   // no input is taken while an argument run is in progress
   a_no_req_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.accepted && !rsp.last |-> !req.ready)
      else $error("input taken during argument drain");

   // a drained argument is followed at once by the next one
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.accepted && !rsp.last |=> rsp.valid && rsp.accepted)
      else $error("argument run broken");

   // indexes advance by one within a run
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.accepted && !rsp.last
      |=> rsp.arg_index == $past(rsp.arg_index) + 5'd1)
      else $error("argument index skipped");

endmodule
`default_nettype wire
